// File: hw/rtl/badc_pkg.sv
// Shared types, codes and arithmetic helpers for the backlight auto-dim controller.
// No dependencies; imported by badc_ctrl and backlight_auto_dim_controller.
package badc_pkg;

  localparam int unsigned TimeoutW = 16;
  localparam int unsigned PctW     = 7;
  localparam int unsigned DutyW    = 10;
  localparam int unsigned PvW      = 8;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [TimeoutW-1:0] DIM1_RESET = 16'd60;
  localparam logic [TimeoutW-1:0] DIM2_RESET = 16'd300;
  localparam logic [TimeoutW-1:0] OFF_RESET  = 16'd600;

  localparam logic [PctW-1:0] PCT_FULL     = 7'd100;
  localparam logic [PctW-1:0] PCT_USER_MIN = 7'd10;
  localparam logic [PctW-1:0] PCT_DIM_MIN  = 7'd5;

  // Duty is 1023*pct/100; with pct below 128 the product with 670434
  // shifted down by 16 gives the same truncated quotient.
  localparam int unsigned DutyMulW  = 20;
  localparam logic [DutyMulW-1:0] DUTY_MUL = 20'd670434;
  localparam int unsigned DutyShift = 16;

  // One fifth of a level below 128 as (v * 205) >> 10.
  localparam logic [7:0] FIFTH_MUL   = 8'd205;
  localparam int unsigned FifthShift = 10;

  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_ACTIVITY = 2'd1,
    KIND_SET_PCT  = 2'd2,
    KIND_UNUSED   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_ACTIVE = 2'd0,
    PH_DIM1   = 2'd1,
    PH_DIM2   = 2'd2,
    PH_OFF    = 2'd3
  } phase_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIM1_TIMEOUT = 2'd0,
    CFG_DIM2_TIMEOUT = 2'd1,
    CFG_OFF_TIMEOUT  = 2'd2,
    CFG_DIM_INHIBIT  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [TimeoutW-1:0] dim1_timeout_s;
    logic [TimeoutW-1:0] dim2_timeout_s;
    logic [TimeoutW-1:0] off_timeout_s;
    logic                dim_inhibit;
  } cfg_t;

  typedef struct packed {
    logic            update;
    logic            fade;
    logic [PctW-1:0] level;
    phase_t          phase;
  } result_t;

  function automatic logic [DutyW-1:0] duty_of(input logic [PctW-1:0] pct);
    logic [PctW+DutyMulW-1:0] prod;
    prod = {{DutyMulW{1'b0}}, pct} * {{PctW{1'b0}}, DUTY_MUL};
    return prod[DutyShift +: DutyW];
  endfunction

  function automatic logic [PctW-1:0] floor_dim(input logic [PctW-1:0] v);
    return (v < PCT_DIM_MIN) ? PCT_DIM_MIN : v;
  endfunction

  function automatic logic [PctW-1:0] fifth_of(input logic [PctW-1:0] v);
    logic [PctW+9:0] prod;
    prod = {10'd0, v} * {{(PctW+2){1'b0}}, FIFTH_MUL};
    return prod[FifthShift +: PctW];
  endfunction

endpackage

// File: hw/rtl/badc_ctrl.sv
// Dimming state and per-item decision logic of the backlight auto-dim controller.
// Depends on badc_pkg for the kind and phase codes, the config struct and helpers.
module badc_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [1:0]                  kind,
  input  logic [badc_pkg::PvW-1:0]    percent_value,
  input  badc_pkg::cfg_t              cfg,
  output badc_pkg::result_t           res
);
  import badc_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [TimeoutW-1:0] idle_r, idle_nxt;
  logic                started_r, started_nxt;
  logic                wake_r, wake_nxt;
  logic [PctW-1:0]     user_r, user_nxt;
  logic [PctW-1:0]     cur_r, cur_nxt;
  logic [PctW-1:0]     clamped;
  logic                upd, fad;
  logic                auto_on;

  always_comb begin
    if (percent_value > {1'b0, PCT_FULL}) begin
      clamped = PCT_FULL;
    end else if (percent_value < {1'b0, PCT_USER_MIN}) begin
      clamped = PCT_USER_MIN;
    end else begin
      clamped = percent_value[PctW-1:0];
    end
  end

  assign auto_on = (cfg.dim1_timeout_s != '0) && !cfg.dim_inhibit && started_r;

  always_comb begin
    phase_nxt   = phase_r;
    idle_nxt    = idle_r;
    started_nxt = started_r;
    wake_nxt    = wake_r;
    user_nxt    = user_r;
    cur_nxt     = cur_r;
    upd         = 1'b0;
    fad         = 1'b0;
    case (kind_t'(kind))
      KIND_TICK: begin
        // The seconds count saturates and is advanced before any compare.
        if (idle_r != '1) begin
          idle_nxt = idle_r + 1'b1;
        end
        if (wake_r) begin
          wake_nxt = 1'b0;
          cur_nxt  = user_r;
          upd      = 1'b1;
        end else if (auto_on) begin
          if (idle_nxt >= cfg.off_timeout_s && phase_r != PH_OFF) begin
            phase_nxt = PH_OFF;
            cur_nxt   = '0;
            upd       = 1'b1;
            fad       = 1'b1;
          end else if (idle_nxt >= cfg.dim2_timeout_s &&
                       (phase_r == PH_ACTIVE || phase_r == PH_DIM1)) begin
            phase_nxt = PH_DIM2;
            cur_nxt   = floor_dim(fifth_of(user_r));
            upd       = 1'b1;
            fad       = 1'b1;
          end else if (idle_nxt >= cfg.dim1_timeout_s && phase_r == PH_ACTIVE) begin
            phase_nxt = PH_DIM1;
            cur_nxt   = floor_dim({1'b0, user_r[PctW-1:1]});
            upd       = 1'b1;
            fad       = 1'b1;
          end
        end
      end
      KIND_ACTIVITY: begin
        idle_nxt    = '0;
        started_nxt = 1'b1;
        if (phase_r != PH_ACTIVE) begin
          phase_nxt = PH_ACTIVE;
          wake_nxt  = 1'b1;
        end
      end
      KIND_SET_PCT: begin
        user_nxt = clamped;
        if (phase_r == PH_ACTIVE) begin
          cur_nxt = clamped;
          upd     = 1'b1;
          fad     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign res = '{update: upd, fade: fad, level: cur_nxt, phase: phase_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_ACTIVE;
      idle_r    <= '0;
      started_r <= 1'b0;
      wake_r    <= 1'b0;
      user_r    <= PCT_FULL;
      cur_r     <= '0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      idle_r    <= idle_nxt;
      started_r <= started_nxt;
      wake_r    <= wake_nxt;
      user_r    <= user_nxt;
      cur_r     <= cur_nxt;
    end
  end

`ifndef SYNTHESIS
  // A wake can only be pending once the phase has returned to active.
  a_wake_active: assert property (@(posedge clk) disable iff (!rst_n)
    wake_r |-> phase_r == PH_ACTIVE)
    else $error("wake pending outside the active phase");

  // The off phase always shows a dark backlight.
  a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_OFF |-> cur_r == '0)
    else $error("backlight lit in the off phase");

  // The stored user level never leaves its clamp range.
  a_user_range: assert property (@(posedge clk) disable iff (!rst_n)
    user_r >= PCT_USER_MIN && user_r <= PCT_FULL)
    else $error("user level out of range");
`endif

endmodule

// File: hw/rtl/backlight_auto_dim_controller.sv
// Top level of the backlight auto-dim controller: stream ports, config registers,
// input and result registers. Depends on badc_pkg and badc_ctrl.
//
//   channel   direction  payload                                       handshake
//   in_       slave      tuser: kind[1:0]; tdata: percent_value[7:0]   tvalid/tready
//   out_      master     tdata: update, fade, pct, duty, phase          tvalid/tready
//   cfg_      write      cfg_index selects register, cfg_wdata value   cfg_we, no wait
//
// An item is taken into the input register; once the result register is free or
// draining, its result is worked out and written to the result register while the
// dimming state updates. One item per cycle is sustained while out_tready stays high.
// The input register keeps accepting while a result waits, until both stages are full.
// rst_n is synchronous and active low; it restores the register defaults and the
// active phase at full user brightness with the backlight dark.
module backlight_auto_dim_controller #(
  parameter logic [badc_pkg::TimeoutW-1:0] Dim1Reset = badc_pkg::DIM1_RESET,
  parameter logic [badc_pkg::TimeoutW-1:0] Dim2Reset = badc_pkg::DIM2_RESET,
  parameter logic [badc_pkg::TimeoutW-1:0] OffReset  = badc_pkg::OFF_RESET
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [1:0]                     in_tuser,   // kind[1:0]
  input  logic [7:0]                     in_tdata,   // percent_value[7:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // update[0], fade[1], brightness_pct[8:2], duty[18:9], dim_phase[20:19], zero fill
  output logic [23:0]                    out_tdata,
  input  logic                           cfg_we,
  input  logic [badc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [badc_pkg::TimeoutW-1:0]  cfg_wdata
);
  import badc_pkg::*;

  cfg_t             cfg_r;
  logic             s1_valid_r;
  logic [1:0]       s1_kind_r;
  logic [PvW-1:0]   s1_pv_r;
  logic             s1_adv;
  logic             out_valid_r;
  result_t          res;
  result_t          out_res_r;
  logic [DutyW-1:0] out_duty_r;

  // Configuration writes land directly in their registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{dim1_timeout_s: Dim1Reset, dim2_timeout_s: Dim2Reset,
                 off_timeout_s: OffReset, dim_inhibit: 1'b0};
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DIM1_TIMEOUT: cfg_r.dim1_timeout_s <= cfg_wdata;
        CFG_DIM2_TIMEOUT: cfg_r.dim2_timeout_s <= cfg_wdata;
        CFG_OFF_TIMEOUT:  cfg_r.off_timeout_s  <= cfg_wdata;
        CFG_DIM_INHIBIT:  cfg_r.dim_inhibit    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // The decision stage moves on whenever the result register is free or draining.
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r <= in_tuser;
      s1_pv_r   <= in_tdata;
    end
  end

  badc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (s1_valid_r && s1_adv),
    .kind          (s1_kind_r),
    .percent_value (s1_pv_r),
    .cfg           (cfg_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Duty is derived from the new level here, one constant multiply.
  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_res_r  <= res;
      out_duty_r <= duty_of(res.level);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.phase, out_duty_r, out_res_r.level,
                       out_res_r.fade, out_res_r.update};

`ifndef SYNTHESIS
  // A faded change is always a change.
  a_fade_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.fade |-> out_res_r.update)
    else $error("fade reported without an update");

  // Duty is zero exactly when the brightness is zero.
  a_duty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_res_r.level == '0) == (out_duty_r == '0)))
    else $error("duty and brightness disagree on dark");

  // Full brightness gives full duty.
  a_duty_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.level == PCT_FULL |-> out_duty_r == '1)
    else $error("full brightness without full duty");

  // A held item in the decision stage is not lost while the output stalls.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_kind_r))
    else $error("decision stage dropped a stalled item");
`endif

endmodule
